// ===== hdl/sorted_matrix_staircase_search_assert.svh =====
// ----------------------------------------------------------------------------
// Assertion macros for the staircase search block
// Shared property forms, clocked on i_clk and disabled during reset.
// ----------------------------------------------------------------------------
`ifndef SORTED_MATRIX_STAIRCASE_SEARCH_ASSERT_SVH
`define SORTED_MATRIX_STAIRCASE_SEARCH_ASSERT_SVH

// Consequent must hold in the same cycle as the antecedent.
`define SMSS_ASSERT_SAME(label, ante, cons, msg) \
    label: assert property (@(posedge i_clk) disable iff (!i_rst_n) \
        (ante) |-> (cons)) else $error(msg);

// Consequent must hold in the cycle after the antecedent.
`define SMSS_ASSERT_NEXT(label, ante, cons, msg) \
    label: assert property (@(posedge i_clk) disable iff (!i_rst_n) \
        (ante) |=> (cons)) else $error(msg);

`endif

// ===== hdl/smss_pkg.sv =====
// ----------------------------------------------------------------------------
// smss_pkg
// Shared constants and types of the sorted-matrix staircase search block.
// ----------------------------------------------------------------------------
package smss_pkg;

    // Default sizes of the matrix store.
    localparam int DEF_MAX_ROWS    = 32;
    localparam int DEF_MAX_COLS    = 32;
    localparam int DEF_VALUE_WIDTH = 32;

    // Fixed field widths.
    localparam int AREA_W     = 6;
    localparam int IDX_W      = 5;
    localparam int IN_VALUE_W = 32;
    localparam int CFG_IDX_W  = 2;

    // Configuration register indexes and reset values.
    localparam logic [CFG_IDX_W-1:0] REG_ROWS = 2'd0;
    localparam logic [CFG_IDX_W-1:0] REG_COLS = 2'd1;
    localparam logic [AREA_W-1:0]    AREA_RESET = 6'd32;

    // Item opcodes.
    localparam logic OP_WRITE = 1'b0;

    // Clamped search area.
    typedef struct packed {
        logic [AREA_W-1:0] nrows;
        logic [AREA_W-1:0] ncols;
    } t_area;

    // One search result.
    typedef struct packed {
        logic             found;
        logic [IDX_W-1:0] hit_row;
        logic [IDX_W-1:0] hit_col;
    } t_result;

endpackage

// ===== hdl/smss_mem.sv =====
// ----------------------------------------------------------------------------
// smss_mem
// Matrix store: one write port, one read port with registered read data.
// ----------------------------------------------------------------------------
module smss_mem #(
    parameter int DEPTH  = 1024,
    parameter int ADDR_W = 10,
    parameter int DATA_W = 32
) (
    input  logic              i_clk,
    input  logic              i_wr_en,
    input  logic [ADDR_W-1:0] i_wr_addr,
    input  logic [DATA_W-1:0] i_wr_data,
    input  logic [ADDR_W-1:0] i_rd_addr,
    output logic [DATA_W-1:0] o_rd_data
);

    logic [DATA_W-1:0] r_mem [DEPTH];
    logic [DATA_W-1:0] r_rd_data;

    // Write port.
    always_ff @(posedge i_clk) begin
        if (i_wr_en) begin
            r_mem[i_wr_addr] <= i_wr_data;
        end
    end

    // Read port, registered read data.
    always_ff @(posedge i_clk) begin
        r_rd_data <= r_mem[i_rd_addr];
    end

    assign o_rd_data = r_rd_data;

endmodule

// ===== hdl/smss_ctrl.sv =====
// ----------------------------------------------------------------------------
// smss_ctrl
// Item sequencer: decodes writes and walks the staircase path of a search,
// one store read per step, tracking the store address incrementally.
// ----------------------------------------------------------------------------
`include "sorted_matrix_staircase_search_assert.svh"

module smss_ctrl import smss_pkg::*; #(
    parameter int MAX_ROWS    = DEF_MAX_ROWS,
    parameter int MAX_COLS    = DEF_MAX_COLS,
    parameter int VALUE_WIDTH = DEF_VALUE_WIDTH,
    parameter int ADDR_W      = 10
) (
    input  logic                          i_clk,
    input  logic                          i_rst_n,
    input  logic                          i_in_valid,
    output logic                          o_in_stall,
    input  logic                          i_opcode,
    input  logic [IDX_W-1:0]              i_entry_row,
    input  logic [IDX_W-1:0]              i_entry_col,
    input  logic signed [VALUE_WIDTH-1:0] i_key,
    input  t_area                         i_area,
    output logic                          o_wr_en,
    output logic [ADDR_W-1:0]             o_wr_addr,
    output logic [ADDR_W-1:0]             o_rd_addr,
    input  logic signed [VALUE_WIDTH-1:0] i_rd_data,
    output logic                          o_res_valid,
    output t_result                       o_res,
    input  logic                          i_res_take
);

    typedef enum logic [2:0] {
        ST_IDLE   = 3'b001,
        ST_SEARCH = 3'b010,
        ST_FINISH = 3'b100
    } t_state;

    localparam logic [ADDR_W-1:0] COL_STEP = ADDR_W'(MAX_COLS);

    t_state                   r_state, n_state;
    logic [AREA_W-1:0]        r_row, n_row;
    logic [AREA_W-1:0]        r_col, n_col;
    logic [ADDR_W-1:0]        r_addr, n_addr;
    logic signed [VALUE_WIDTH-1:0] r_key, n_key;
    t_result                  r_res, n_res;

    logic              wr_in_range;
    logic              area_empty;
    logic [ADDR_W-1:0] start_addr;
    logic              key_eq;
    logic              key_lt;

    // Write address and range check.
    assign wr_in_range = (32'(i_entry_row) < MAX_ROWS) && (32'(i_entry_col) < MAX_COLS);
    assign o_wr_addr   = ADDR_W'(32'(i_entry_row) * MAX_COLS + 32'(i_entry_col));

    // Bottom-left corner of the area.
    assign area_empty = (i_area.nrows == '0) || (i_area.ncols == '0);
    assign start_addr = ADDR_W'(32'(i_area.nrows - 6'd1) * MAX_COLS);

    // Compare the key with the entry read in the previous cycle.
    assign key_eq = (r_key == i_rd_data);
    assign key_lt = (r_key < i_rd_data);

    // Next-state logic: write decode, the search walk and the result hand-over.
    always_comb begin
        n_state = r_state;
        n_row   = r_row;
        n_col   = r_col;
        n_addr  = r_addr;
        n_key   = r_key;
        n_res   = r_res;
        o_wr_en = 1'b0;
        unique case (r_state)
            ST_IDLE: begin
                if (i_in_valid) begin
                    if (i_opcode == OP_WRITE) begin
                        o_wr_en = wr_in_range;
                    end else begin
                        n_key = i_key;
                        n_res = '0;
                        if (area_empty) begin
                            n_state = ST_FINISH;
                        end else begin
                            n_row   = i_area.nrows;
                            n_col   = '0;
                            n_addr  = start_addr;
                            n_state = ST_SEARCH;
                        end
                    end
                end
            end
            ST_SEARCH: begin
                if (key_eq) begin
                    n_res.found   = 1'b1;
                    n_res.hit_row = IDX_W'(r_row - 6'd1);
                    n_res.hit_col = IDX_W'(r_col);
                    n_state       = ST_FINISH;
                end else if (key_lt) begin
                    if (r_row == 6'd1) begin
                        n_state = ST_FINISH;
                    end else begin
                        n_row  = r_row - 6'd1;
                        n_addr = r_addr - COL_STEP;
                    end
                end else begin
                    if ((r_col + 6'd1) >= i_area.ncols) begin
                        n_state = ST_FINISH;
                    end else begin
                        n_col  = r_col + 6'd1;
                        n_addr = r_addr + ADDR_W'(1);
                    end
                end
            end
            ST_FINISH: begin
                if (i_res_take) begin
                    n_state = ST_IDLE;
                end
            end
            default: begin
                n_state = ST_IDLE;
            end
        endcase
    end

    // The store is read at the next position every cycle.
    assign o_rd_addr = n_addr;

    // Control state.
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= ST_IDLE;
        end else begin
            r_state <= n_state;
        end
    end

    // Walk position, key and result.
    always_ff @(posedge i_clk) begin
        r_row  <= n_row;
        r_col  <= n_col;
        r_addr <= n_addr;
        r_key  <= n_key;
        r_res  <= n_res;
    end

    assign o_in_stall  = (r_state != ST_IDLE);
    assign o_res_valid = (r_state == ST_FINISH);
    assign o_res       = r_res;

    // Checks.
    `SMSS_ASSERT_SAME(a_addr_tracks_pos, r_state == ST_SEARCH, r_addr == ADDR_W'(32'(r_row - 6'd1) * MAX_COLS + 32'(r_col)), "store address out of step with position")
    `SMSS_ASSERT_SAME(a_pos_in_area, r_state == ST_SEARCH, (r_row != '0) && (r_row <= i_area.nrows) && (r_col < i_area.ncols), "search position outside the area")
    `SMSS_ASSERT_NEXT(a_search_starts, (r_state == ST_IDLE) && i_in_valid && (i_opcode != OP_WRITE) && !area_empty, (r_state == ST_SEARCH) && (r_col == '0) && (r_row == $past(i_area.nrows)), "search did not start at the corner")
    `SMSS_ASSERT_NEXT(a_res_holds, o_res_valid && !i_res_take, o_res_valid && $stable(o_res), "pending result changed before it was taken")
    `SMSS_ASSERT_SAME(a_no_write_busy, o_wr_en, r_state == ST_IDLE, "store written during a search")

endmodule

// ===== hdl/sorted_matrix_staircase_search.sv =====
// ----------------------------------------------------------------------------
// sorted_matrix_staircase_search
// A write beat is taken while idle. A search registers its key and start corner,
// then walks the staircase with one store read per step (at most rows + columns
// - 1 steps, 63 at 32 by 32), then holds its result until the result is taken.
// Reset clears control state and sets both area registers to 32; the store
// holds no defined value until written.
// ----------------------------------------------------------------------------
module sorted_matrix_staircase_search import smss_pkg::*; #(
    parameter int MAX_ROWS    = DEF_MAX_ROWS,
    parameter int MAX_COLS    = DEF_MAX_COLS,
    parameter int VALUE_WIDTH = DEF_VALUE_WIDTH
) (
    input  logic                         i_clk,
    input  logic                         i_rst_n,
    // Item input channel.
    input  logic                         i_in_valid,
    output logic                         o_in_stall,
    input  logic                         i_opcode,
    input  logic [IDX_W-1:0]             i_entry_row,
    input  logic [IDX_W-1:0]             i_entry_col,
    input  logic signed [IN_VALUE_W-1:0] i_data_value,
    // Result channel.
    output logic                         o_out_valid,
    input  logic                         i_out_stall,
    output logic                         o_found,
    output logic [IDX_W-1:0]             o_hit_row,
    output logic [IDX_W-1:0]             o_hit_col,
    // Configuration write channel.
    input  logic                         i_cfg_valid,
    output logic                         o_cfg_ready,
    input  logic [CFG_IDX_W-1:0]         i_cfg_index,
    input  logic [AREA_W-1:0]            i_cfg_data
);

    localparam int DEPTH  = MAX_ROWS * MAX_COLS;
    localparam int ADDR_W = (DEPTH > 1) ? $clog2(DEPTH) : 1;

    logic [AREA_W-1:0] r_rows_cfg;
    logic [AREA_W-1:0] r_cols_cfg;
    t_area             area;

    logic signed [VALUE_WIDTH-1:0] key;
    logic signed [VALUE_WIDTH-1:0] rd_data;
    logic                          wr_en;
    logic [ADDR_W-1:0]             wr_addr;
    logic [ADDR_W-1:0]             rd_addr;
    logic                          res_valid;
    t_result                       res;
    logic                          out_free;

    logic                          r_out_valid;
    t_result                       r_out;

    // Configuration registers; writes are always taken.
    assign o_cfg_ready = 1'b1;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_rows_cfg <= AREA_RESET;
            r_cols_cfg <= AREA_RESET;
        end else if (i_cfg_valid) begin
            unique case (i_cfg_index)
                REG_ROWS: r_rows_cfg <= i_cfg_data;
                REG_COLS: r_cols_cfg <= i_cfg_data;
                default: ;
            endcase
        end
    end

    // Clamp the area to the store size.
    assign area.nrows = (32'(r_rows_cfg) > MAX_ROWS) ? AREA_W'(MAX_ROWS) : r_rows_cfg;
    assign area.ncols = (32'(r_cols_cfg) > MAX_COLS) ? AREA_W'(MAX_COLS) : r_cols_cfg;

    // Values are held at the store width, sign-extended or truncated.
    assign key = VALUE_WIDTH'(i_data_value);

    smss_ctrl #(
        .MAX_ROWS    (MAX_ROWS),
        .MAX_COLS    (MAX_COLS),
        .VALUE_WIDTH (VALUE_WIDTH),
        .ADDR_W      (ADDR_W)
    ) u_ctrl (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_in_valid  (i_in_valid),
        .o_in_stall  (o_in_stall),
        .i_opcode    (i_opcode),
        .i_entry_row (i_entry_row),
        .i_entry_col (i_entry_col),
        .i_key       (key),
        .i_area      (area),
        .o_wr_en     (wr_en),
        .o_wr_addr   (wr_addr),
        .o_rd_addr   (rd_addr),
        .i_rd_data   (rd_data),
        .o_res_valid (res_valid),
        .o_res       (res),
        .i_res_take  (out_free)
    );

    smss_mem #(
        .DEPTH  (DEPTH),
        .ADDR_W (ADDR_W),
        .DATA_W (VALUE_WIDTH)
    ) u_mem (
        .i_clk     (i_clk),
        .i_wr_en   (wr_en),
        .i_wr_addr (wr_addr),
        .i_wr_data (key),
        .i_rd_addr (rd_addr),
        .o_rd_data (rd_data)
    );

    // Output register: loads when empty or when its beat is taken.
    assign out_free = !r_out_valid || !i_out_stall;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_out_valid <= 1'b0;
        end else if (out_free) begin
            r_out_valid <= res_valid;
        end
    end

    always_ff @(posedge i_clk) begin
        if (out_free && res_valid) begin
            r_out <= res;
        end
    end

    assign o_out_valid = r_out_valid;
    assign o_found     = r_out.found;
    assign o_hit_row   = r_out.hit_row;
    assign o_hit_col   = r_out.hit_col;

endmodule
